// ----- sv/grey_error_diffusion_dither_assert.svh -----
// Assertion macros shared by the dither RTL.
`ifndef GREY_ERROR_DIFFUSION_DITHER_ASSERT_SVH
`define GREY_ERROR_DIFFUSION_DITHER_ASSERT_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define GEDD_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Default form: clk_i and rst_ni of the enclosing module.
`define GEDD_ASSERT(label, prop, msg) \
  `GEDD_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ----- sv/gedd_pkg.sv -----
// Types, constants and codes of the grey error diffusion dither.
package gedd_pkg;

  localparam int MAX_LINE_DEFAULT = 1024;

  localparam int PIX_W  = 8;
  localparam int POS_W  = 13;
  localparam int ORG_W  = 12;
  localparam int ROW_W  = 12;
  localparam int LW_W   = 11;
  localparam int LEV_W  = 9;
  localparam int ERR_W  = 12;
  localparam int SUM_W  = 14;
  localparam int QZ_W   = 12;
  localparam int T_W    = 9;
  localparam int Q_W    = 8;
  localparam int M_W    = 21;
  localparam int RECIP_SHIFT = 21;
  localparam int DIV_DW = 22;
  localparam int CFG_DW = 12;
  localparam int CFG_IW = 3;

  localparam int GREY_MAX = 255;
  localparam logic [ERR_W-1:0] SEED_ROW   = ERR_W'((9 * GREY_MAX) / 32);
  localparam logic [ERR_W-1:0] SEED_RIGHT = ERR_W'((7 * GREY_MAX) / 32);
  localparam logic [ERR_W-1:0] SEED_DIAG  = ERR_W'(GREY_MAX / 32);

  // reset values of the derived divisor, step and reciprocal (two levels)
  localparam logic [T_W-1:0] T_RESET = T_W'(512 / 2);
  localparam logic [Q_W-1:0] Q_RESET = Q_W'(GREY_MAX / 1);
  localparam logic [M_W-1:0] M_RESET = M_W'((1 << RECIP_SHIFT) / 256);

  typedef enum logic [CFG_IW-1:0] {
    CFG_LINE_WIDTH  = 3'd0,
    CFG_GREY_LEVELS = 3'd1,
    CFG_DITHER_MODE = 3'd2,
    CFG_BANDPASS    = 3'd3,
    CFG_MONO_THR    = 3'd4,
    CFG_ORIGIN_X    = 3'd5,
    CFG_ORIGIN_Y    = 3'd6
  } cfg_reg_e;

  typedef enum logic [2:0] {
    DP_IDLE,
    DP_START_T,
    DP_T,
    DP_Q,
    DP_M
  } div_phase_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM,
    ST_MUL,
    ST_LVL,
    ST_WR0,
    ST_WR1,
    ST_OUT
  } dith_state_e;

  typedef struct packed {
    logic [LW_W-1:0]  line_width;
    logic             dither_mode;
    logic [PIX_W-1:0] bandpass;
    logic [PIX_W-1:0] mono_thr;
    logic [ORG_W-1:0] origin_x;
    logic [ORG_W-1:0] origin_y;
    logic             two_level;
    logic [T_W-1:0]   t;
    logic [Q_W-1:0]   q;
    logic [M_W-1:0]   m;
    logic             busy;
  } cfg_t;

  typedef struct packed {
    logic             tag;
    logic [ERR_W-1:0] err;
  } row_word_t;

endpackage

// ----- sv/gedd_if.sv -----
// Pixel input and result output stream interfaces.
interface gedd_pix_if;
  logic                        valid;
  logic                        ready;
  logic [gedd_pkg::PIX_W-1:0]  pixel_grey;
  logic                        region_start;

  modport source (output valid, output pixel_grey, output region_start, input ready);
  modport sink (input valid, input pixel_grey, input region_start, output ready);
endinterface

interface gedd_res_if;
  logic                        valid;
  logic                        ready;
  logic [gedd_pkg::PIX_W-1:0]  level_out;
  logic [gedd_pkg::POS_W-1:0]  pos_x;
  logic [gedd_pkg::POS_W-1:0]  pos_y;

  modport source (output valid, output level_out, output pos_x, output pos_y, input ready);
  modport sink (input valid, input level_out, input pos_x, input pos_y, output ready);
endinterface

// ----- sv/gedd_ram.sv -----
// Generic RAM: one write port, two registered read ports.
module gedd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ----- sv/gedd_div.sv -----
// Restoring divider, one quotient bit per cycle.
module gedd_div #(
  parameter int DivW = 22,
  parameter int VsrW = 9
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [VsrW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] quot_o
);

  localparam int CntW = $clog2(DivW + 1);

  logic [DivW-1:0] dq_q;
  logic [VsrW-1:0] rem_q;
  logic [VsrW-1:0] dv_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [VsrW:0]   trial;
  logic            ge;
  logic [VsrW:0]   diff;

  assign trial = {rem_q, dq_q[DivW-1]};
  assign ge    = trial >= {1'b0, dv_q};
  assign diff  = trial - {1'b0, dv_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(DivW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= dividend_i;
      rem_q <= '0;
      dv_q  <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[DivW-2:0], ge};
      rem_q <= ge ? diff[VsrW-1:0] : trial[VsrW-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

// ----- sv/gedd_cfg.sv -----
// Configuration registers and derived quantizer constants.
module gedd_cfg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gedd_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [gedd_pkg::CFG_DW-1:0] cfg_wdata_i,
  output gedd_pkg::cfg_t              cfg_o
);
  import gedd_pkg::*;

  logic [LW_W-1:0]  line_width_q;
  logic [LEV_W-1:0] levels_q;
  logic             dither_q;
  logic [PIX_W-1:0] bandpass_q;
  logic [PIX_W-1:0] mono_thr_q;
  logic [ORG_W-1:0] origin_x_q;
  logic [ORG_W-1:0] origin_y_q;
  logic [T_W-1:0]   t_q;
  logic [Q_W-1:0]   q_q;
  logic [M_W-1:0]   m_q;
  div_phase_e       phase_q, phase_d;

  logic              lev_wr;
  logic [LEV_W-1:0]  lev_c;
  logic              div_start;
  logic [DIV_DW-1:0] div_dividend;
  logic [T_W-1:0]    div_divisor;
  logic              div_done;
  logic [DIV_DW-1:0] div_quot;

  assign lev_wr = cfg_we_i && (cfg_reg_e'(cfg_idx_i) == CFG_GREY_LEVELS);

  always_comb begin
    if (levels_q < LEV_W'(2)) begin
      lev_c = LEV_W'(2);
    end else if (levels_q > LEV_W'(256)) begin
      lev_c = LEV_W'(256);
    end else begin
      lev_c = levels_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LW_W'(128);
      levels_q     <= LEV_W'(2);
      dither_q     <= 1'b1;
      bandpass_q   <= '0;
      mono_thr_q   <= PIX_W'(127);
      origin_x_q   <= '0;
      origin_y_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_LINE_WIDTH:  line_width_q <= cfg_wdata_i[LW_W-1:0];
        CFG_GREY_LEVELS: levels_q     <= cfg_wdata_i[LEV_W-1:0];
        CFG_DITHER_MODE: dither_q     <= cfg_wdata_i[0];
        CFG_BANDPASS:    bandpass_q   <= cfg_wdata_i[PIX_W-1:0];
        CFG_MONO_THR:    mono_thr_q   <= cfg_wdata_i[PIX_W-1:0];
        CFG_ORIGIN_X:    origin_x_q   <= cfg_wdata_i[ORG_W-1:0];
        CFG_ORIGIN_Y:    origin_y_q   <= cfg_wdata_i[ORG_W-1:0];
        default: ;
      endcase
    end
  end

  // t = 512 / L, q = 255 / (L - 1), m = ceil(2^21 / t)
  always_comb begin
    phase_d      = phase_q;
    div_start    = 1'b0;
    div_dividend = DIV_DW'(512);
    div_divisor  = lev_c;
    unique case (phase_q)
      DP_IDLE: ;
      DP_START_T: begin
        div_start = 1'b1;
        phase_d   = DP_T;
      end
      DP_T: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = DIV_DW'(GREY_MAX);
          div_divisor  = lev_c - 1'b1;
          phase_d      = DP_Q;
        end
      end
      DP_Q: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = DIV_DW'(1 << RECIP_SHIFT) + DIV_DW'(t_q) - DIV_DW'(1);
          div_divisor  = t_q;
          phase_d      = DP_M;
        end
      end
      DP_M: begin
        if (div_done) begin
          phase_d = DP_IDLE;
        end
      end
      default: phase_d = DP_IDLE;
    endcase
    if (lev_wr) begin
      phase_d   = DP_START_T;
      div_start = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= DP_IDLE;
      t_q     <= T_RESET;
      q_q     <= Q_RESET;
      m_q     <= M_RESET;
    end else begin
      phase_q <= phase_d;
      if (div_done && !lev_wr) begin
        if (phase_q == DP_T) t_q <= div_quot[T_W-1:0];
        if (phase_q == DP_Q) q_q <= div_quot[Q_W-1:0];
        if (phase_q == DP_M) m_q <= div_quot[M_W-1:0];
      end
    end
  end

  gedd_div #(
    .DivW (DIV_DW),
    .VsrW (T_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    cfg_o.line_width  = line_width_q;
    cfg_o.dither_mode = dither_q;
    cfg_o.bandpass    = bandpass_q;
    cfg_o.mono_thr    = mono_thr_q;
    cfg_o.origin_x    = origin_x_q;
    cfg_o.origin_y    = origin_y_q;
    cfg_o.two_level   = lev_c == LEV_W'(2);
    cfg_o.t           = t_q;
    cfg_o.q           = q_q;
    cfg_o.m           = m_q;
    cfg_o.busy        = phase_q != DP_IDLE;
  end

endmodule

// ----- sv/grey_error_diffusion_dither.sv -----
// Top level: grey error diffusion dither with per-column row error memory.
`include "grey_error_diffusion_dither_assert.svh"

// Takes grey pixels in raster order and returns one display level per pixel with its
// display position. In error diffusion mode a pixel goes from transfer to a result in the
// output register by reading the row error memory, then the error sum, the reciprocal
// multiply and the level multiply, then writing back the current and the left column
// entries through the single write port of that memory. In direct mode a pixel goes
// straight to the output step. After reset the memory is cleared entry by entry before
// the first pixel is taken. A write of grey_levels recomputes the quantizer step and
// its reciprocal in a serial divider, which holds off input until it is done.
module grey_error_diffusion_dither #(
  parameter int MaxLine = gedd_pkg::MAX_LINE_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gedd_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [gedd_pkg::CFG_DW-1:0] cfg_wdata_i,
  gedd_pix_if.sink                    pix_i,
  gedd_res_if.source                  res_o
);
  import gedd_pkg::*;

  localparam int ColW  = $clog2(MaxLine);
  localparam int WideW = ColW + 1;
  localparam int WordW = ERR_W + 1;

  cfg_t        cfg;
  dith_state_e state_q, state_d;

  logic [ColW-1:0]  clr_q;
  logic             parity_q;
  logic [ColW-1:0]  col_q;
  logic [ROW_W-1:0] row_q;
  logic [ERR_W-1:0] right_q;
  logic [ERR_W-1:0] diag_q;
  logic             res_valid_q;

  logic [PIX_W-1:0] g_q;
  logic [ColW-1:0]  c_q;
  logic             cnz_q;
  logic             row_end_q;
  logic [POS_W-1:0] posx_q;
  logic [POS_W-1:0] posy_q;
  logic [PIX_W-1:0] level_q;
  logic [SUM_W-1:0] sum_q;
  row_word_t        prev_q;
  logic [QZ_W-1:0]  qz_q;
  logic [ERR_W-1:0] k_q;
  logic [PIX_W-1:0] res_level_q;
  logic [POS_W-1:0] res_x_q;
  logic [POS_W-1:0] res_y_q;

  logic             pix_fire;
  logic             out_free;
  logic             rs;
  logic [WideW-1:0] width_eff;
  logic [WideW-1:0] col_base;
  logic [ColW-1:0]  c;
  logic [WideW-1:0] c_next;
  logic             row_end;
  logic [ColW-1:0]  col_d;
  logic [ROW_W-1:0] row_base;
  logic [ROW_W-1:0] row_d;
  logic [PIX_W-1:0] g_in;
  logic [PIX_W-1:0] g_band;
  logic [PIX_W-1:0] lvl_direct;

  logic             ram_we;
  logic [ColW-1:0]  ram_waddr;
  row_word_t        ram_wdata;
  logic [WordW-1:0] ram_rdata_a;
  logic [WordW-1:0] ram_rdata_b;
  row_word_t        rd_a;
  row_word_t        rd_b;

  logic [ERR_W-1:0] below;
  logic [SUM_W-1:0] sum;
  logic [ERR_W:0]   sum_pos;
  logic [33:0]      prod;
  logic [19:0]      lv;
  logic [PIX_W-1:0] lvl_dith;
  logic [SUM_W-1:0] r;
  logic [ERR_W-1:0] k12;
  logic [ERR_W-1:0] k7;
  logic [ERR_W-1:0] k5d;
  logic [ERR_W-1:0] k3p;
  logic [ERR_W-1:0] diag_new;

  gedd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign pix_i.ready = (state_q == ST_IDLE) && !cfg.busy;
  assign pix_fire    = pix_i.valid && pix_i.ready;
  assign out_free    = !res_valid_q || res_o.ready;
  assign rs          = pix_i.region_start;
  assign g_in        = pix_i.pixel_grey;

  // column and row bookkeeping for the incoming pixel
  always_comb begin
    if (cfg.line_width == '0) begin
      width_eff = WideW'(1);
    end else if (32'(cfg.line_width) > MaxLine) begin
      width_eff = WideW'(MaxLine);
    end else begin
      width_eff = WideW'(cfg.line_width);
    end
    col_base = rs ? '0 : {1'b0, col_q};
    c        = (col_base >= width_eff) ? '0 : col_base[ColW-1:0];
    c_next   = {1'b0, c} + 1'b1;
    row_end  = c_next >= width_eff;
    col_d    = row_end ? '0 : c_next[ColW-1:0];
    row_base = rs ? '0 : row_q;
    row_d    = row_end ? row_base + 1'b1 : row_base;
  end

  always_comb begin
    g_band = g_in;
    if (cfg.bandpass != '0) begin
      if (g_in >= PIX_W'(GREY_MAX) - cfg.bandpass) begin
        g_band = PIX_W'(GREY_MAX);
      end else if (g_in <= cfg.bandpass) begin
        g_band = '0;
      end
    end
    if (!cfg.two_level) begin
      lvl_direct = g_in;
    end else if (g_in <= cfg.mono_thr) begin
      lvl_direct = '0;
    end else begin
      lvl_direct = PIX_W'(GREY_MAX);
    end
  end

  gedd_ram #(
    .Width (WordW),
    .Depth (MaxLine)
  ) u_row_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (c),
    .rdata_a_o (ram_rdata_a),
    .raddr_b_i (c - 1'b1),
    .rdata_b_o (ram_rdata_b)
  );

  assign rd_a = row_word_t'(ram_rdata_a);
  assign rd_b = row_word_t'(ram_rdata_b);

  // error sum, quotient by reciprocal, level, residual split
  always_comb begin
    below    = (rd_a.tag == parity_q) ? rd_a.err : SEED_ROW;
    sum      = {{(SUM_W-PIX_W){1'b0}}, g_q}
             + {{(SUM_W-ERR_W){right_q[ERR_W-1]}}, right_q}
             + {{(SUM_W-ERR_W){below[ERR_W-1]}}, below};
    sum_pos  = (sum_q[SUM_W-1]) ? '0 : sum_q[ERR_W:0];
    prod     = 34'(sum_pos) * 34'(cfg.m);
    lv       = 20'(qz_q) * 20'(cfg.q);
    lvl_dith = (lv > 20'(GREY_MAX)) ? PIX_W'(GREY_MAX) : lv[PIX_W-1:0];
    r        = sum_q - {{(SUM_W-PIX_W){1'b0}}, level_q};
    k12      = {{2{r[SUM_W-1]}}, r[SUM_W-1:4]};
    k7       = (k12 << 3) - k12;
    k5d      = (k12 << 2) + k12 + diag_q;
    diag_new = {{(ERR_W-4){1'b0}}, r[3:0]} + k12;
    k3p      = (k_q << 1) + k_q + prev_q.err;
  end

  always_comb begin
    state_d   = state_q;
    ram_we    = 1'b0;
    ram_waddr = c_q;
    ram_wdata = '0;
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        if (clr_q == ColW'(MaxLine - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (pix_fire) state_d = cfg.dither_mode ? ST_SUM : ST_OUT;
      end
      ST_SUM: state_d = ST_MUL;
      ST_MUL: state_d = ST_LVL;
      ST_LVL: state_d = ST_WR0;
      ST_WR0: begin
        ram_we        = 1'b1;
        ram_wdata.tag = parity_q;
        ram_wdata.err = k5d;
        state_d       = ST_WR1;
      end
      ST_WR1: begin
        ram_we        = cnz_q;
        ram_waddr     = c_q - 1'b1;
        ram_wdata.tag = prev_q.tag;
        ram_wdata.err = k3p;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      parity_q    <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      right_q     <= SEED_RIGHT;
      diag_q      <= SEED_DIAG;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (pix_fire) begin
        parity_q <= parity_q ^ rs;
        col_q    <= col_d;
        row_q    <= row_d;
        if (rs || (!cfg.dither_mode && row_end)) begin
          right_q <= SEED_RIGHT;
          diag_q  <= SEED_DIAG;
        end
      end
      if (state_q == ST_WR0) begin
        right_q <= row_end_q ? SEED_RIGHT : k7;
        diag_q  <= row_end_q ? SEED_DIAG : diag_new;
      end
      if (state_q == ST_OUT && out_free) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_fire) begin
      g_q       <= cfg.dither_mode ? g_band : g_in;
      c_q       <= c;
      cnz_q     <= c != '0;
      row_end_q <= row_end;
      posx_q    <= POS_W'(cfg.origin_x) + POS_W'(c);
      posy_q    <= POS_W'(cfg.origin_y) + POS_W'(row_base);
      level_q   <= lvl_direct;
    end
    if (state_q == ST_SUM) begin
      sum_q  <= sum;
      prev_q <= rd_b;
    end
    if (state_q == ST_MUL) qz_q <= prod[RECIP_SHIFT +: QZ_W];
    if (state_q == ST_LVL) level_q <= lvl_dith;
    if (state_q == ST_WR0) k_q <= k12;
    if (state_q == ST_OUT && out_free) begin
      res_level_q <= level_q;
      res_x_q     <= posx_q;
      res_y_q     <= posy_q;
    end
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.level_out = res_level_q;
  assign res_o.pos_x     = res_x_q;
  assign res_o.pos_y     = res_y_q;

  `GEDD_ASSERT(a_dither_enters_sum, pix_fire && cfg.dither_mode |=> state_q == ST_SUM, "dither pixel did not start the error sum")
  `GEDD_ASSERT(a_nonpos_sum_black, state_q == ST_WR0 && (sum_q[SUM_W-1] || sum_q == '0) |-> level_q == '0, "nonpositive error sum gave a nonzero level")
  `GEDD_ASSERT(a_left_write_addr, state_q == ST_WR1 && cnz_q |-> ram_waddr != $past(ram_waddr), "left column write hit the current column")
  `GEDD_ASSERT(a_result_from_out, $rose(res_valid_q) |-> $past(state_q) == ST_OUT, "result loaded outside the output step")

endmodule
